### rtl/sri_pkg.sv
// Package for the servo recipe interpreter: shared types, codes, constants
// and the duty lookup. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package sri_pkg;

    // Default sizes of the block.
    localparam int DEF_RECIPES   = 8;
    localparam int DEF_STEPS     = 32;
    localparam int DEF_POSITIONS = 6;

    // Width of the flat store address before it is trimmed to the depth.
    // Enough for the largest store of 32 recipes of 32 steps.
    localparam int ADDR_CALC_W = 11;

    // Item kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_BEGIN = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_PAUSE = 3'd2,
        MODE_END   = 3'd3,
        MODE_ERROR = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        NUDGE_NONE  = 2'd0,
        NUDGE_LEFT  = 2'd1,
        NUDGE_RIGHT = 2'd2
    } t_nudge;

    // Recipe opcodes, bits 7:5 of a recipe byte.
    localparam logic [2:0] OP_END     = 3'd0;
    localparam logic [2:0] OP_MOV     = 3'd1;
    localparam logic [2:0] OP_WAIT    = 3'd2;
    localparam logic [2:0] OP_LOAD    = 3'd3;
    localparam logic [2:0] OP_LOOP    = 3'd4;
    localparam logic [2:0] OP_ENDLOOP = 3'd5;

    // LED codes.
    localparam logic [2:0] LED_NONE      = 3'd0;
    localparam logic [2:0] LED_PAUSED    = 3'd1;
    localparam logic [2:0] LED_END       = 3'd2;
    localparam logic [2:0] LED_CMD_ERR   = 3'd3;
    localparam logic [2:0] LED_NEST_ERR  = 3'd4;

    // Error kinds.
    localparam logic ERR_COMMAND = 1'b0;
    localparam logic ERR_NESTED  = 1'b1;

    // ASCII user keys.
    localparam logic [7:0] KEY_L_UP = 8'h4C;
    localparam logic [7:0] KEY_L_LO = 8'h6C;
    localparam logic [7:0] KEY_R_UP = 8'h52;
    localparam logic [7:0] KEY_R_LO = 8'h72;
    localparam logic [7:0] KEY_P_UP = 8'h50;
    localparam logic [7:0] KEY_P_LO = 8'h70;
    localparam logic [7:0] KEY_C_UP = 8'h43;
    localparam logic [7:0] KEY_C_LO = 8'h63;
    localparam logic [7:0] KEY_B_UP = 8'h42;
    localparam logic [7:0] KEY_B_LO = 8'h62;

    // Configuration register word indexes.
    localparam logic REG_START_RECIPE = 1'b0;

    // One accepted input transaction.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] key;
        logic [2:0] recipe_sel;
        logic [4:0] step_sel;
        logic [7:0] recipe_byte;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [2:0] servo_position;
        logic [4:0] duty;
        logic [2:0] led_code;
        logic [2:0] mode;
    } t_result;

    // Recipe store access issued by the interpreter core.
    typedef struct packed {
        logic                   we;
        logic [ADDR_CALC_W-1:0] waddr;
        logic [7:0]             wdata;
        logic                   re;
        logic [ADDR_CALC_W-1:0] raddr;
    } t_mem_req;

    // PWM duty per position; positions past the table give zero.
    function automatic logic [4:0] duty_of(input logic [7:0] pos);
        logic [4:0] d;
        case (pos)
            8'd0:    d = 5'd5;
            8'd1:    d = 5'd9;
            8'd2:    d = 5'd13;
            8'd3:    d = 5'd17;
            8'd4:    d = 5'd20;
            8'd5:    d = 5'd24;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

### rtl/sri_store.sv
// Recipe store of the servo recipe interpreter: one synchronous RAM with a
// registered read and a same-edge write bypass. Depends on sri_pkg.
`timescale 1ns / 1ps

module sri_store #(
    parameter int RECIPES = sri_pkg::DEF_RECIPES,
    parameter int STEPS   = sri_pkg::DEF_STEPS
) (
    input  logic              i_clk,
    input  sri_pkg::t_mem_req i_req,
    output logic [7:0]        o_fetch
);
    import sri_pkg::*;

    localparam int DEPTH  = RECIPES * STEPS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        r_rdata;
    logic [7:0]        r_fwd_data;
    logic              r_fwd_hit;

    assign waddr = ADDR_W'(i_req.waddr);
    assign raddr = ADDR_W'(i_req.raddr);

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[waddr] <= i_req.wdata;
        end
    end

    // The read data holds until the next read, so a stalled item keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata    <= mem[raddr];
            r_fwd_hit  <= i_req.we && (i_req.waddr == i_req.raddr);
            r_fwd_data <= i_req.wdata;
        end
    end

    assign o_fetch = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

### rtl/sri_core.sv
// Interpreter core of the servo recipe interpreter: architectural state,
// step execution, key handling and recipe store requests. Depends on sri_pkg.
`timescale 1ns / 1ps

module sri_core #(
    parameter int RECIPES   = sri_pkg::DEF_RECIPES,
    parameter int STEPS     = sri_pkg::DEF_STEPS,
    parameter int POSITIONS = sri_pkg::DEF_POSITIONS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  logic              i_accept,
    input  sri_pkg::t_item    i_item,
    input  logic [7:0]        i_fetch,
    input  logic [2:0]        i_start_recipe,
    output sri_pkg::t_result  o_result,
    output sri_pkg::t_mem_req o_mem_req
);
    import sri_pkg::*;

    localparam int AR_W  = (RECIPES > 8) ? $clog2(RECIPES) : 3;
    localparam int POS_W = $clog2(POSITIONS);

    t_mode             r_mode,     n_mode;
    logic [4:0]        r_pc,       n_pc;
    logic [4:0]        r_wait,     n_wait;
    logic [4:0]        r_loop,     n_loop;
    logic [4:0]        r_loop_pc,  n_loop_pc;
    logic [AR_W-1:0]   r_recipe,   n_recipe;
    logic              r_err,      n_err;
    logic [POS_W-1:0]  r_pos,      n_pos;
    t_nudge            r_nudge,    n_nudge;
    logic              r_fetch_ok;

    logic [7:0] fetch_byte;
    logic [2:0] op;
    logic [4:0] arg;
    logic [4:0] pc_inc;
    logic [4:0] wait_dec;
    logic [5:0] pos6;
    logic [2:0] led;
    logic       is_l, is_r, is_p, is_c, is_b;
    logic [7:0] pos_ext;
    logic       wr_ok;
    logic       rd_ok;

    // An out-of-range fetch reads as the end opcode.
    assign fetch_byte = r_fetch_ok ? i_fetch : 8'h00;
    assign op         = fetch_byte[7:5];
    assign arg        = fetch_byte[4:0];
    assign pc_inc     = r_pc + 5'd1;
    assign wait_dec   = r_wait - 5'd1;
    assign pos6       = 6'(r_pos);

    assign is_l = (i_item.key == KEY_L_UP) || (i_item.key == KEY_L_LO);
    assign is_r = (i_item.key == KEY_R_UP) || (i_item.key == KEY_R_LO);
    assign is_p = (i_item.key == KEY_P_UP) || (i_item.key == KEY_P_LO);
    assign is_c = (i_item.key == KEY_C_UP) || (i_item.key == KEY_C_LO);
    assign is_b = (i_item.key == KEY_B_UP) || (i_item.key == KEY_B_LO);

    always_comb begin
        n_mode    = r_mode;
        n_pc      = r_pc;
        n_wait    = r_wait;
        n_loop    = r_loop;
        n_loop_pc = r_loop_pc;
        n_recipe  = r_recipe;
        n_err     = r_err;
        n_pos     = r_pos;
        n_nudge   = r_nudge;
        led       = LED_NONE;
        if (i_exec) begin
            case (i_item.cmd)
                CMD_TICK: begin
                    unique case (r_mode)
                        MODE_RUN: begin
                            case (op)
                                OP_MOV: begin
                                    if (6'(arg) >= 6'(POSITIONS)) begin
                                        n_err  = ERR_COMMAND;
                                        n_mode = MODE_ERROR;
                                    end else begin
                                        n_pos = POS_W'(arg);
                                        n_pc  = pc_inc;
                                    end
                                end
                                OP_WAIT: begin
                                    if (r_wait == 5'd0) begin
                                        n_wait = arg;
                                    end else begin
                                        n_wait = wait_dec;
                                        if (wait_dec == 5'd0) begin
                                            n_pc = pc_inc;
                                        end
                                    end
                                end
                                OP_LOOP: begin
                                    if (r_loop != 5'd0) begin
                                        n_err  = ERR_NESTED;
                                        n_mode = MODE_ERROR;
                                    end else begin
                                        n_loop    = arg;
                                        n_loop_pc = pc_inc;
                                        n_pc      = pc_inc;
                                    end
                                end
                                OP_ENDLOOP: begin
                                    if (r_loop == 5'd0) begin
                                        n_pc = pc_inc;
                                    end else begin
                                        n_loop = r_loop - 5'd1;
                                        n_pc   = r_loop_pc;
                                    end
                                end
                                OP_END: begin
                                    n_mode = MODE_END;
                                end
                                OP_LOAD: begin
                                    if (6'(arg) < 6'(RECIPES)) begin
                                        n_pc     = 5'd0;
                                        n_recipe = AR_W'(arg);
                                        n_mode   = MODE_RUN;
                                    end else begin
                                        n_err  = ERR_COMMAND;
                                        n_mode = MODE_ERROR;
                                    end
                                end
                                default: begin
                                    n_err  = ERR_COMMAND;
                                    n_mode = MODE_ERROR;
                                end
                            endcase
                        end
                        MODE_BEGIN, MODE_PAUSE: begin
                            // Left moves up the position table, right moves down.
                            case (r_nudge)
                                NUDGE_LEFT: begin
                                    if (pos6 + 6'd1 < 6'(POSITIONS)) begin
                                        n_pos = r_pos + POS_W'(1);
                                    end
                                end
                                NUDGE_RIGHT: begin
                                    if (pos6 != 6'd0) begin
                                        n_pos = r_pos - POS_W'(1);
                                    end
                                end
                                default: begin
                                end
                            endcase
                            n_nudge = NUDGE_NONE;
                            led     = (r_mode == MODE_PAUSE) ? LED_PAUSED : LED_NONE;
                        end
                        MODE_END: begin
                            led = LED_END;
                        end
                        MODE_ERROR: begin
                            led = r_err ? LED_NEST_ERR : LED_CMD_ERR;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_KEY: begin
                    unique case (r_mode)
                        MODE_BEGIN: begin
                            if (is_l) begin
                                n_nudge = NUDGE_LEFT;
                            end else if (is_r) begin
                                n_nudge = NUDGE_RIGHT;
                            end else if (is_c || is_b) begin
                                n_mode = MODE_RUN;
                            end
                        end
                        MODE_RUN: begin
                            if (is_p) begin
                                n_mode = MODE_PAUSE;
                            end else if (is_b) begin
                                n_pc = 5'd0;
                            end
                        end
                        MODE_PAUSE: begin
                            if (is_l) begin
                                n_nudge = NUDGE_LEFT;
                            end else if (is_r) begin
                                n_nudge = NUDGE_RIGHT;
                            end else if (is_c) begin
                                n_mode = MODE_RUN;
                            end else if (is_b) begin
                                n_pc   = 5'd0;
                                n_mode = MODE_RUN;
                            end
                        end
                        MODE_END, MODE_ERROR: begin
                            if (is_b) begin
                                n_pc   = 5'd0;
                                n_mode = MODE_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_WRITE: begin
                end
                CMD_RESTART: begin
                    // Loop counter, error kind and pending nudge survive a restart.
                    n_mode   = MODE_BEGIN;
                    n_recipe = AR_W'(i_start_recipe);
                    n_pc     = 5'd0;
                    n_wait   = 5'd0;
                    n_pos    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BEGIN;
            r_pc      <= 5'd0;
            r_wait    <= 5'd0;
            r_loop    <= 5'd0;
            r_loop_pc <= 5'd0;
            r_recipe  <= '0;
            r_err     <= ERR_COMMAND;
            r_pos     <= '0;
            r_nudge   <= NUDGE_NONE;
        end else begin
            r_mode    <= n_mode;
            r_pc      <= n_pc;
            r_wait    <= n_wait;
            r_loop    <= n_loop;
            r_loop_pc <= n_loop_pc;
            r_recipe  <= n_recipe;
            r_err     <= n_err;
            r_pos     <= n_pos;
            r_nudge   <= n_nudge;
        end
    end

    // Marks whether the byte fetched for the waiting item came from a valid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_ok <= 1'b0;
        end else if (i_accept) begin
            r_fetch_ok <= rd_ok;
        end
    end

    // The next item's fetch uses the state this item leaves behind.
    assign rd_ok = (6'(n_recipe) < 6'(RECIPES)) && (6'(n_pc) < 6'(STEPS));
    assign wr_ok = (6'(i_item.recipe_sel) < 6'(RECIPES)) &&
                   (6'(i_item.step_sel) < 6'(STEPS));

    always_comb begin
        o_mem_req.we    = i_exec && (i_item.cmd == CMD_WRITE) && wr_ok;
        o_mem_req.waddr = ADDR_CALC_W'(i_item.recipe_sel) * ADDR_CALC_W'(STEPS)
                          + ADDR_CALC_W'(i_item.step_sel);
        o_mem_req.wdata = i_item.recipe_byte;
        o_mem_req.re    = i_accept && rd_ok;
        o_mem_req.raddr = ADDR_CALC_W'(n_recipe) * ADDR_CALC_W'(STEPS)
                          + ADDR_CALC_W'(n_pc);
    end

    assign pos_ext                 = 8'(n_pos);
    assign o_result.servo_position = pos_ext[2:0];
    assign o_result.duty           = duty_of(pos_ext);
    assign o_result.led_code       = led;
    assign o_result.mode           = n_mode;

endmodule

### rtl/servo_recipe_interpreter.sv
// Top level of the servo recipe interpreter: stream handshakes, APB
// configuration register, result register. Depends on sri_pkg, sri_store
// and sri_core.
`timescale 1ns / 1ps

// Channel       Direction  Handshake                       Payload
// s_axis        in         s_axis_tvalid / s_axis_tready   tuser cmd, tdata item fields
// m_axis        out        m_axis_tvalid / m_axis_tready   tdata position, duty, LED, mode
// apb           in/out     psel, penable, pwrite, pready   start_recipe at word 0
//
// Each transaction waits in the fetch stage, where its recipe memory read
// data arrives, and executes from there into the result register. The fetch
// address is formed from the state the executing transaction leaves, so a new
// transaction can be taken every cycle while m_axis is not stalled: sustained
// rate one per cycle. The result passes through the fetch stage and the
// result register before it shows on m_axis; the recipe memory read is
// registered.
// Reset is synchronous and active low; the recipe store is not cleared.
// A stall on m_axis holds the fetch stage, and s_axis_tready drops only
// while both stages are full and the result is not taken.

module servo_recipe_interpreter #(
    parameter int RECIPES   = sri_pkg::DEF_RECIPES,
    parameter int STEPS     = sri_pkg::DEF_STEPS,
    parameter int POSITIONS = sri_pkg::DEF_POSITIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    // [7:0] key, [10:8] recipe_sel, [15:11] step_sel, [23:16] recipe_byte
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] servo_position, [7:3] duty, [10:8] led_code, [13:11] mode, [15:14] zero
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sri_pkg::*;

    logic       r_s1_valid;
    t_item      r_s1_item;
    logic       r_out_valid;
    t_result    r_out;
    logic [2:0] r_start_recipe;

    logic       accept;
    logic       exec;
    logic       cfg_write;
    logic [7:0] fetch;
    t_result    result;
    t_mem_req   mem_req;

    // The fetch stage executes once the result register is free or being drained.
    assign exec          = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || exec;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (exec) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.cmd         <= t_cmd'(s_axis_tuser);
            r_s1_item.key         <= s_axis_tdata[7:0];
            r_s1_item.recipe_sel  <= s_axis_tdata[10:8];
            r_s1_item.step_sel    <= s_axis_tdata[15:11];
            r_s1_item.recipe_byte <= s_axis_tdata[23:16];
        end
    end

    sri_store #(
        .RECIPES (RECIPES),
        .STEPS   (STEPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_fetch (fetch)
    );

    sri_core #(
        .RECIPES   (RECIPES),
        .STEPS     (STEPS),
        .POSITIONS (POSITIONS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_exec         (exec),
        .i_accept       (accept),
        .i_item         (r_s1_item),
        .i_fetch        (fetch),
        .i_start_recipe (r_start_recipe),
        .o_result       (result),
        .o_mem_req      (mem_req)
    );

    // Result register: one transaction per executed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.mode, r_out.led_code, r_out.duty,
                            r_out.servo_position};

    // APB: a single register at word 0, written on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_START_RECIPE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_recipe <= 3'd0;
        end else if (cfg_write) begin
            r_start_recipe <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_START_RECIPE) ? {29'd0, r_start_recipe} : 32'd0;

endmodule
